// File: hw/rtl/q248_pkg.sv
// Package for the signed Q24.8 fixed-point ALU: word types, op codes, constants.
// No dependencies.
package q248_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 8;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_LT    = 4'd4,
    OP_GT    = 4'd5,
    OP_LE    = 4'd6,
    OP_GE    = 4'd7,
    OP_EQ    = 4'd8,
    OP_NE    = 4'd9,
    OP_MIN   = 4'd10,
    OP_MAX   = 4'd11,
    OP_INC   = 4'd12,
    OP_DEC   = 4'd13,
    OP_TOINT = 4'd14,
    OP_NONE  = 4'd15
  } op_t;

  typedef struct packed {
    logic        [3:0]  kind;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic               divide_by_zero;
  } out_word_t;

endpackage

// File: hw/rtl/signed_q24_8_fixed_point_alu.sv
// Top level of the signed Q24.8 fixed-point ALU.
// Depends on q248_pkg, q248_mul, q248_div.
//
// Usage:
//   in channel:  in_valid / in_ready / in_data (in_word_t: kind, operand_a, operand_b)
//   out channel: out_valid / out_ready / out_data (out_word_t)
//   Every op flows through one pipeline of LAT stages; LAT = 32 + FRACTION_BITS + 2,
//   set by the bit-per-stage divider.
//   One word is accepted per cycle and one result given per cycle while the pipeline advances.
//   Multiply takes 64-bit magnitude product in registered 16-bit partial steps,
//   divide one quotient bit per stage; signs are applied at the end.
//   When out_ready is low the whole pipeline holds; a word only enters when the
//   pipeline advances, and nothing is lost or repeated.
//   in_ready = out_ready or output register empty.
//   Reset (rst, synchronous) clears all valid bits; payload is not reset.
//   Divide by zero returns 0 with divide_by_zero set; code 15 returns all zeros.
module signed_q24_8_fixed_point_alu #(
  parameter int FRACTION_BITS = q248_pkg::FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  q248_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output q248_pkg::out_word_t  out_data
);
  import q248_pkg::*;

  localparam int NW  = 32 + FRACTION_BITS;
  localparam int LAT = NW + 2;

  logic adv;
  assign adv      = out_ready || !out_valid;
  assign in_ready = adv;

  // stage 0 side logic: magnitudes and simple results
  logic [31:0] a, b, mag_a, mag_b;
  logic        neg, lt, gt, eq;
  logic [31:0] simple_res;
  logic        simple_cmp;
  op_t         op;

  always_comb begin
    a     = in_data.operand_a;
    b     = in_data.operand_b;
    op    = op_t'(in_data.kind);
    mag_a = a[31] ? 32'(-a) : a;
    mag_b = b[31] ? 32'(-b) : b;
    neg   = a[31] ^ b[31];
    lt    = $signed(a) < $signed(b);
    gt    = $signed(b) < $signed(a);
    eq    = a == b;
    simple_res = '0;
    simple_cmp = 1'b0;
    case (op)
      OP_ADD:   simple_res = a + b;
      OP_SUB:   simple_res = a - b;
      OP_LT:    simple_cmp = lt;
      OP_GT:    simple_cmp = gt;
      OP_LE:    simple_cmp = !gt;
      OP_GE:    simple_cmp = !lt;
      OP_EQ:    simple_cmp = eq;
      OP_NE:    simple_cmp = !eq;
      OP_MIN:   simple_res = lt ? a : b;
      OP_MAX:   simple_res = gt ? a : b;
      OP_INC:   simple_res = a + 32'd1;
      OP_DEC:   simple_res = a - 32'd1;
      OP_TOINT: simple_res = 32'($signed(a) >>> FRACTION_BITS);
      default:  ;
    endcase
  end

  // multiplier: two 32x16 partial products, each registered
  logic [63:0] mul_prod;
  q248_mul u_mul (
    .clk(clk), .en(adv), .mag_a(mag_a), .mag_b(mag_b), .product(mul_prod)
  );
  // delay product to the pipe end
  logic [63:0] mul_d [LAT-2];
  assign mul_d[0] = mul_prod;
  for (genvar i = 1; i < LAT - 2; i++) begin : g_md
    always_ff @(posedge clk) if (adv) mul_d[i] <= mul_d[i-1];
  end

  // divider
  logic [NW-1:0] quo;
  logic [NW-1:0] quo_r;
  q248_div #(.FRAC(FRACTION_BITS)) u_div (
    .clk(clk), .en(adv), .dividend(mag_a), .divisor(mag_b), .quotient(quo)
  );

  // side-band delay line
  typedef struct packed {
    logic        valid;
    logic [3:0]  kind;
    logic        neg;
    logic        dz;
    logic [31:0] res;
    logic        cmp;
  } side_t;

  side_t side [LAT];
  always_comb begin
    side[0].valid = in_valid;
    side[0].kind  = in_data.kind;
    side[0].neg   = neg;
    side[0].dz    = (b == 32'd0);
    side[0].res   = simple_res;
    side[0].cmp   = simple_cmp;
  end
  for (genvar i = 0; i < LAT - 1; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        side[i+1].valid <= 1'b0;
      end else if (adv) begin
        side[i+1].valid <= side[i].valid;
      end
      if (adv) begin
        side[i+1].kind <= side[i].kind;
        side[i+1].neg  <= side[i].neg;
        side[i+1].dz   <= side[i].dz;
        side[i+1].res  <= side[i].res;
        side[i+1].cmp  <= side[i].cmp;
      end
    end
  end

  always_ff @(posedge clk) if (adv) begin
    quo_r <= quo;
  end

  // final: sign apply and select (stage LAT-1 -> LAT output register)
  side_t       last;
  logic [31:0] mag_m, mag_q, fin;
  logic [63:0] shp;
  always_comb begin
    last  = side[LAT-1];
    shp   = mul_d[LAT-3] >> FRACTION_BITS;
    mag_m = shp[31:0];
    mag_q = quo_r[31:0];
    fin   = last.res;
    case (op_t'(last.kind))
      OP_MUL: fin = last.neg ? 32'(-mag_m) : mag_m;
      OP_DIV: fin = last.dz ? 32'd0 : (last.neg ? 32'(-mag_q) : mag_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= last.valid;
    end
    if (adv) begin
      out_data.result_value   <= fin;
      out_data.compare_true   <= last.cmp;
      out_data.divide_by_zero <= (op_t'(last.kind) == OP_DIV) && last.dz;
    end
  end
endmodule

// File: hw/rtl/q248_div.sv
// Pipelined restoring divider: one quotient bit per stage, one word per cycle while en is high.
// Depends on q248_pkg. Quotient = (|a| << FRAC) / |b|, magnitudes only.
module q248_div #(
  parameter int FRAC = q248_pkg::FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [31:0]               dividend,
  input  logic [31:0]               divisor,
  output logic [32+FRAC-1:0]        quotient
);
  import q248_pkg::*;

  localparam int NW = 32 + FRAC;

  logic [NW-1:0] num [NW+1];
  logic [NW-1:0] quo [NW+1];
  logic [32:0]   rem [NW+1];
  logic [31:0]   den [NW+1];

  assign num[0] = {dividend, FRAC'(0)};
  assign quo[0] = '0;
  assign rem[0] = '0;
  assign den[0] = divisor;

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [32:0] shifted;
    logic [32:0] diff;
    logic        take;
    always_comb begin
      shifted = {rem[i][31:0], num[i][NW-1]};
      diff    = shifted - {1'b0, den[i]};
      take    = !diff[32];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        num[i+1] <= num[i] << 1;
        den[i+1] <= den[i];
        rem[i+1] <= take ? diff : shifted;
        quo[i+1] <= {quo[i][NW-2:0], take};
      end
    end
  end

  assign quotient = quo[NW];
endmodule

// File: hw/rtl/q248_mul.sv
// Pipelined 32x32 magnitude multiplier, two registered stages: 32x16 partials, then their sum.
// Depends on q248_pkg.
module q248_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] mag_a,
  input  logic [31:0] mag_b,
  output logic [63:0] product
);
  import q248_pkg::*;

  // 32x16 partials against each half of b, summed in the next stage
  logic [47:0] pm_lo, pm_hi;

  always_ff @(posedge clk) begin
    if (en) begin
      pm_lo   <= 48'(mag_a) * 48'(mag_b[15:0]);
      pm_hi   <= 48'(mag_a) * 48'(mag_b[31:16]);
      product <= 64'(pm_lo) + (64'(pm_hi) << 16);
    end
  end
endmodule

// File: dv/tb_signed_q24_8_fixed_point_alu.sv
// Testbench for the signed Q24.8 fixed-point ALU: directed corners, then random words
// under three idle patterns and one long output stall, checked by a scoreboard class.
// Depends on q248_pkg and signed_q24_8_fixed_point_alu.
module tb_signed_q24_8_fixed_point_alu;
  timeunit 1ns;
  timeprecision 1ps;
  import q248_pkg::*;

  class alu_scoreboard;
    out_word_t pending[$];
    int errors;
    int checked;

    function out_word_t compute(in_word_t w);
      out_word_t r;
      logic signed [31:0] a, b;
      logic [63:0] ma, mb, mag;
      logic neg;
      a = w.operand_a;
      b = w.operand_b;
      r = '0;
      ma = a[31] ? {32'd0, -a} : {32'd0, a};
      mb = b[31] ? {32'd0, -b} : {32'd0, b};
      neg = a[31] ^ b[31];
      case (op_t'(w.kind))
        OP_ADD: r.result_value = a + b;
        OP_SUB: r.result_value = a - b;
        OP_MUL: begin
          mag = (ma * mb) >> FRAC_BITS;
          r.result_value = neg ? -mag[31:0] : mag[31:0];
        end
        OP_DIV: begin
          if (b == 0) r.divide_by_zero = 1'b1;
          else begin
            mag = (ma << FRAC_BITS) / mb;
            r.result_value = neg ? -mag[31:0] : mag[31:0];
          end
        end
        OP_LT: r.compare_true = a < b;
        OP_GT: r.compare_true = a > b;
        OP_LE: r.compare_true = a <= b;
        OP_GE: r.compare_true = a >= b;
        OP_EQ: r.compare_true = a == b;
        OP_NE: r.compare_true = a != b;
        OP_MIN: r.result_value = (a < b) ? a : b;
        OP_MAX: r.result_value = (a > b) ? a : b;
        OP_INC: r.result_value = a + 32'sd1;
        OP_DEC: r.result_value = a - 32'sd1;
        OP_TOINT: r.result_value = a >>> FRAC_BITS;
        default: r = '0;
      endcase
      return r;
    endfunction

    function void note_input(in_word_t w);
      pending.push_back(compute(w));
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, checked);
    endtask

    task check_result(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        report("unexpected word", got.result_value, 32'd0);
        return;
      end
      want = pending.pop_front();
      if (got.result_value !== want.result_value)
        report("result_value", got.result_value, want.result_value);
      if (got.compare_true !== want.compare_true)
        report("compare_true", 32'(got.compare_true), 32'(want.compare_true));
      if (got.divide_by_zero !== want.divide_by_zero)
        report("divide_by_zero", 32'(got.divide_by_zero), 32'(want.divide_by_zero));
      checked++;
    endtask
  endclass

  localparam int LATENCY = 32 + FRAC_BITS + 2;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;

  alu_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_output = 1'b0;
  int sent = 0;
  int idle_cycles = 0;

  signed_q24_8_fixed_point_alu i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // receiver: sample at the edge, then decide ready for the next cycle
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    if (!rst && (in_valid && in_ready || out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    out_ready <= !hold_output && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("Timeout: no handshake for %0d cycles", WATCHDOG);
      $display("Mismatches found");
      $finish;
    end
  end

  function logic [31:0] rand_operand();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7fff_ffff - $urandom_range(3);
      2: return $urandom_range(8) - 4;
      3: return {$urandom_range(1) ? 24'hffffff : 24'h0, 8'($urandom)};
      4: return 32'($urandom) >>> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  // valid stays high across back-to-back words; it only drops in idle cycles
  task send_word(logic [3:0] kind, logic [31:0] a, logic [31:0] b);
    in_word_t w;
    w.kind = kind;
    w.operand_a = a;
    w.operand_b = b;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_input(w);
    sent++;
  endtask

  task send_random(int count);
    logic [31:0] a;
    repeat (count) begin
      a = rand_operand();
      if ($urandom_range(9) == 0) send_word(4'($urandom_range(15)), a, a);
      else if ($urandom_range(19) == 0) send_word(OP_DIV, a, 32'd0);
      else send_word(4'($urandom_range(15)), a, rand_operand());
    end
  endtask

  initial begin
    int k;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed corners: every op on extremes, divide by zero, overflows, ties
    for (k = 0; k <= 15; k++) send_word(4'(k), 32'h8000_0000, 32'hffff_ff00);
    send_word(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_word(OP_DIV, 32'h7fff_ffff, 32'd0);
    send_word(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    send_word(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    send_word(OP_MIN, 32'h0000_0100, 32'h0000_0100);
    send_word(OP_MAX, 32'hffff_ff00, 32'hffff_ff00);
    send_word(OP_INC, 32'h7fff_ffff, 32'd0);
    send_word(OP_DEC, 32'h8000_0000, 32'd0);
    send_word(OP_TOINT, 32'hffff_ffff, 32'd0);
    send_idle_pct = 22; recv_idle_pct = 64;
    send_random(600);
    send_idle_pct = 64; recv_idle_pct = 22;
    send_random(600);
    send_idle_pct = 0; recv_idle_pct = 0;
    // long output stall while the sender keeps offering words
    fork
      begin
        hold_output = 1'b1;
        repeat (3 * LATENCY) @(posedge clk);
        hold_output = 1'b0;
      end
      send_random(150);
    join
    send_random(650);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d words over all ops, corners, divide by zero and stalls;", sent);
    $display("checked %0d results, %0d errors.", sb.checked, sb.errors);
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
